// ===== rtl/idtp_pkg.sv =====
`default_nettype none

package idtp_pkg;

  localparam logic [7:0] CharDash = 8'h2D;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam logic [3:0] TextLen  = 4'd10;
  localparam logic [3:0] DashPosA = 4'd4;
  localparam logic [3:0] DashPosB = 4'd7;
  localparam logic [3:0] YearEnd  = 4'd4;
  localparam logic [3:0] CentEnd  = 4'd2;
  localparam logic [3:0] MonthEnd = 4'd7;

  localparam int QueueDepth = 2;

  // days from 0000-03-01 to 1970-01-01
  localparam logic signed [23:0] EpochOffset = 24'sd719468;

  // One finished text handed from the character front to the conversion back.
  typedef struct packed {
    logic       fmt_ok;
    logic       leap;
    logic [6:0] year_hi;
    logic [6:0] year_lo;
    logic [6:0] month;
    logic [6:0] day;
  } idtp_rec_t;

  function automatic logic [4:0] days_in_month(input logic [6:0] month, input logic leap);
    logic [4:0] dim;
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: dim = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    dim = 5'd30;
      7'd2:                                       dim = leap ? 5'd29 : 5'd28;
      default:                                    dim = 5'd0;
    endcase
    return dim;
  endfunction

  // Days from March 1 to the first of the month, year starting in March.
  function automatic logic [8:0] month_base(input logic [6:0] month);
    logic [8:0] base;
    case (month)
      7'd1:    base = 9'd306;
      7'd2:    base = 9'd337;
      7'd3:    base = 9'd0;
      7'd4:    base = 9'd31;
      7'd5:    base = 9'd61;
      7'd6:    base = 9'd92;
      7'd7:    base = 9'd122;
      7'd8:    base = 9'd153;
      7'd9:    base = 9'd184;
      7'd10:   base = 9'd214;
      7'd11:   base = 9'd245;
      7'd12:   base = 9'd275;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iso_date_text_parser_core.sv =====
// A text's record goes through the queue, stage A, stage B and the output register.
// Throughput: one character per cycle, back to back; the conversion pipeline takes
// one text per cycle unless out_ready_i stalls, so texts of any length run gap-free.
// The input stalls only while the record queue between parser and converter is full.
// Reset (rst_ni low, asynchronous) clears the parser state, the queue and all valids.
`default_nettype none

module iso_date_text_parser_core import idtp_pkg::*; #(
  parameter int FifoDepth = QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         char_code_i,
  input  wire logic               last_char_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    date_valid_o,
  output logic signed [22:0]      days_since_epoch_o
);

  idtp_rec_t push_rec, pop_rec;
  logic      push, pop, q_full, q_empty;

  idtp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  idtp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (pop_rec)
  );

  idtp_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .rec_i              (pop_rec),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .date_valid_o       (date_valid_o),
    .days_since_epoch_o (days_since_epoch_o)
  );

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !date_valid_o |-> days_since_epoch_o == 23'sd0)
    else $error("invalid date with nonzero day count");

  a_days_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && date_valid_o |->
      (days_since_epoch_o >= -23'sd719528) && (days_since_epoch_o <= 23'sd2932896))
    else $error("day count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/idtp_front.sv =====
`default_nettype none

module idtp_front import idtp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       last_char_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output idtp_rec_t       rec_o
);

  logic [3:0] pos_q, pos_d;
  logic [6:0] yhi_q, yhi_d;
  logic [6:0] ylo_q, ylo_d;
  logic [6:0] mon_q, mon_d;
  logic [6:0] day_q, day_d;
  logic       err_q, err_d;
  logic       accept;
  logic       is_digit;
  logic [3:0] digit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_digit   = (char_code_i >= CharZero) && (char_code_i <= CharNine);
  assign digit      = 4'(char_code_i - CharZero);

  always_comb begin
    pos_d = pos_q;
    yhi_d = yhi_q;
    ylo_d = ylo_q;
    mon_d = mon_q;
    day_d = day_q;
    err_d = err_q;
    if (pos_q >= TextLen) begin
      err_d = 1'b1;
    end else begin
      if (pos_q == DashPosA || pos_q == DashPosB) begin
        if (char_code_i != CharDash) err_d = 1'b1;
      end else if (!is_digit) begin
        err_d = 1'b1;
      end else if (pos_q < CentEnd) begin
        yhi_d = 7'((yhi_q << 3) + (yhi_q << 1) + {3'b0, digit});
      end else if (pos_q < YearEnd) begin
        ylo_d = 7'((ylo_q << 3) + (ylo_q << 1) + {3'b0, digit});
      end else if (pos_q < MonthEnd) begin
        mon_d = 7'((mon_q << 3) + (mon_q << 1) + {3'b0, digit});
      end else begin
        day_d = 7'((day_q << 3) + (day_q << 1) + {3'b0, digit});
      end
      pos_d = pos_q + 4'd1;
    end
  end

  always_comb begin
    rec_o.fmt_ok  = (pos_d == TextLen) && !err_d;
    rec_o.leap    = (ylo_d == 7'd0) ? (yhi_d[1:0] == 2'b00) : (ylo_d[1:0] == 2'b00);
    rec_o.year_hi = yhi_d;
    rec_o.year_lo = ylo_d;
    rec_o.month   = mon_d;
    rec_o.day     = day_d;
  end

  assign push_o = accept && last_char_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      yhi_q <= '0;
      ylo_q <= '0;
      mon_q <= '0;
      day_q <= '0;
      err_q <= 1'b0;
    end else if (accept) begin
      if (last_char_i) begin
        // text done: clear for the next one
        pos_q <= '0;
        yhi_q <= '0;
        ylo_q <= '0;
        mon_q <= '0;
        day_q <= '0;
        err_q <= 1'b0;
      end else begin
        pos_q <= pos_d;
        yhi_q <= yhi_d;
        ylo_q <= ylo_d;
        mon_q <= mon_d;
        day_q <= day_d;
        err_q <= err_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/idtp_fifo.sv =====
`default_nettype none

module idtp_fifo import idtp_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire idtp_rec_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           empty_o,
  output idtp_rec_t      data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  idtp_rec_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= next_ptr(wr_q);
      if (pop_i) rd_q <= next_ptr(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/idtp_back.sv =====
`default_nettype none

module idtp_back import idtp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire idtp_rec_t          rec_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    date_valid_o,
  output logic signed [22:0]      days_since_epoch_o
);

  logic adv;

  // stage A: range checks, March-based year split, day of year
  logic              va_q;
  logic              ok_a_q;
  logic signed [7:0] yh_a_q;
  logic [6:0]        yl_a_q;
  logic [9:0]        doy_a_q;

  // stage B: year value and leap-day corrections plus day of year
  logic               vb_q;
  logic               ok_b_q;
  logic signed [14:0] y_b_q;
  logic signed [15:0] corr_b_q;

  // output register
  logic               vo_q;
  logic               ok_o_q;
  logic signed [22:0] days_o_q;

  logic              ok_a_d;
  logic signed [7:0] yh_a_d;
  logic [6:0]        yl_a_d;
  logic [9:0]        doy_a_d;
  logic [4:0]        dim;
  logic              mon_ok;

  logic signed [14:0] y_b_d;
  logic signed [15:0] corr_b_d;
  logic signed [23:0] days_full;

  assign adv   = !vo_q || out_ready_i;
  assign pop_o = adv && !q_empty_i;

  always_comb begin
    dim     = days_in_month(rec_i.month, rec_i.leap);
    mon_ok  = (rec_i.month >= 7'd1) && (rec_i.month <= 7'd12);
    ok_a_d  = rec_i.fmt_ok && mon_ok && (rec_i.day >= 7'd1) && (rec_i.day <= {2'b0, dim});
    yh_a_d  = $signed({1'b0, rec_i.year_hi});
    yl_a_d  = rec_i.year_lo;
    // Jan and Feb belong to the previous March-based year
    if (rec_i.month <= 7'd2) begin
      if (rec_i.year_lo != 7'd0) begin
        yl_a_d = rec_i.year_lo - 7'd1;
      end else begin
        yl_a_d = 7'd99;
        yh_a_d = $signed({1'b0, rec_i.year_hi}) - 8'sd1;
      end
    end
    doy_a_d = 10'({1'b0, month_base(rec_i.month)} + {3'b0, rec_i.day} - 10'd1);
  end

  always_comb begin
    y_b_d    = 15'(yh_a_q) * 15'sd100 + $signed({8'b0, yl_a_q});
    // floor(y/4) - floor(y/100) + floor(y/400) with y = 100*yh + yl
    corr_b_d = 16'(yh_a_q) * 16'sd24 + $signed({11'b0, yl_a_q[6:2]})
             + 16'(yh_a_q >>> 2) + $signed({6'b0, doy_a_q});
  end

  assign days_full = 24'(y_b_q) * 24'sd365 + 24'(corr_b_q) - EpochOffset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      va_q <= !q_empty_i;
      vb_q <= va_q;
      vo_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_a_q   <= ok_a_d;
      yh_a_q   <= yh_a_d;
      yl_a_q   <= yl_a_d;
      doy_a_q  <= doy_a_d;
      ok_b_q   <= ok_a_q;
      y_b_q    <= y_b_d;
      corr_b_q <= corr_b_d;
      ok_o_q   <= ok_b_q;
      days_o_q <= ok_b_q ? days_full[22:0] : '0;
    end
  end

  assign out_valid_o        = vo_q;
  assign date_valid_o       = ok_o_q;
  assign days_since_epoch_o = days_o_q;

endmodule

`default_nettype wire
